// ===== design/slm_pkg.sv =====
// Package: widths, payload types and latencies of the skew line midpoint block.
package slm_pkg;

  localparam int POINT_WIDTH = 32;
  localparam int DIR_WIDTH   = 16;

  localparam int PW   = POINT_WIDTH;
  localparam int DW   = DIR_WIDTH;
  localparam int WW   = PW + 1;
  localparam int ABW  = 2 * DW + 2;
  localparam int DEW  = DW + WW + 2;
  localparam int DENW = 2 * ABW + 1;
  localparam int NW   = ABW + DEW + 1;
  localparam int PNW  = DW + NW;
  localparam int QSW  = PNW + 1;
  localparam int MSW  = QSW + 2;
  localparam int DFW  = PW + 1;
  localparam int SQW  = 2 * DFW + 2;
  localparam int RW   = SQW / 2;

  localparam int ESPL = DEW / 2;
  localparam int EHW  = DEW - ESPL;
  localparam int ELW  = ESPL + 1;
  localparam int NSPL = NW / 2;
  localparam int NHW  = NW - NSPL;
  localparam int NLW  = NSPL + 1;

  localparam int DIV_LAT  = PNW + 2;
  localparam int SQ_LAT   = RW + 1;
  localparam int TAIL_N   = 3 + SQ_LAT;
  localparam int BACK_LAT = 4 + DIV_LAT + 1 + TAIL_N;

  typedef struct packed {
    logic signed [PW-1:0] p1_x;
    logic signed [PW-1:0] p1_y;
    logic signed [PW-1:0] p1_z;
    logic signed [DW-1:0] v1_x;
    logic signed [DW-1:0] v1_y;
    logic signed [DW-1:0] v1_z;
    logic signed [PW-1:0] p2_x;
    logic signed [PW-1:0] p2_y;
    logic signed [PW-1:0] p2_z;
    logic signed [DW-1:0] v2_x;
    logic signed [DW-1:0] v2_y;
    logic signed [DW-1:0] v2_z;
  } slm_in_t;

  typedef struct packed {
    logic signed [PW-1:0] mid_x;
    logic signed [PW-1:0] mid_y;
    logic signed [PW-1:0] mid_z;
    logic [PW-1:0]        line_distance;
    logic                 lines_parallel;
    logic                 saturated;
  } slm_out_t;

  typedef struct packed {
    logic signed [ABW-1:0] a;
    logic signed [ABW-1:0] b;
    logic signed [ABW-1:0] c;
    logic signed [DEW-1:0] d;
    logic signed [DEW-1:0] e;
    logic [2:0][DW-1:0]    v1;
    logic [2:0][DW-1:0]    v2;
    logic [2:0][WW-1:0]    ps;
    logic [2:0][WW-1:0]    w;
  } slm_dot_t;

endpackage

// ===== design/slm_div.sv =====
// Pipelined signed restoring divider, one quotient bit per stage.
module slm_div import slm_pkg::*; (
  input  logic                   clk,
  input  logic                   en,
  input  logic signed [PNW-1:0]  num,
  input  logic signed [DENW-1:0] den,
  input  logic                   zero,
  output logic signed [QSW-1:0]  quo
);

  logic [DENW-1:0] rem_r  [PNW+1];
  logic [PNW-1:0]  q_r    [PNW+1];
  logic [DENW-1:0] dv_r   [PNW+1];
  logic            neg_r  [PNW+1];
  logic            zero_r [PNW+1];
  logic signed [QSW-1:0] quo_r;
  logic [PNW-1:0]  an;
  logic [DENW-1:0] ad;
  logic [DENW:0]   t  [PNW];
  logic            ge [PNW];
  logic signed [QSW-1:0] qs;

  assign an = num[PNW-1] ? PNW'(-num) : PNW'(num);
  assign ad = den[DENW-1] ? DENW'(-den) : DENW'(den);

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= '0;
      q_r[0]    <= an;
      dv_r[0]   <= ad;
      neg_r[0]  <= num[PNW-1] ^ den[DENW-1];
      zero_r[0] <= zero;
    end
  end

  for (genvar k = 0; k < PNW; k++) begin : g_step
    assign t[k]  = {rem_r[k], q_r[k][PNW-1]};
    assign ge[k] = t[k] >= {1'b0, dv_r[k]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1]  <= ge[k] ? DENW'(t[k] - {1'b0, dv_r[k]}) : t[k][DENW-1:0];
        q_r[k+1]    <= {q_r[k][PNW-2:0], ge[k]};
        dv_r[k+1]   <= dv_r[k];
        neg_r[k+1]  <= neg_r[k];
        zero_r[k+1] <= zero_r[k];
      end
    end
  end

  assign qs = neg_r[PNW] ? -$signed({1'b0, q_r[PNW]}) : $signed({1'b0, q_r[PNW]});

  always_ff @(posedge clk) begin
    if (en) begin
      quo_r <= zero_r[PNW] ? '0 : qs;
    end
  end

  assign quo = quo_r;

endmodule

// ===== design/slm_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
module slm_sqrt import slm_pkg::*; (
  input  logic           clk,
  input  logic           en,
  input  logic [SQW-1:0] rad,
  output logic [RW-1:0]  root
);

  logic [RW+2:0]  rem_r  [RW+1];
  logic [RW-1:0]  root_r [RW+1];
  logic [SQW-1:0] n_r    [RW+1];
  logic [RW+2:0]  r2    [RW];
  logic [RW+2:0]  trial [RW];
  logic           ge    [RW];

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= '0;
      root_r[0] <= '0;
      n_r[0]    <= rad;
    end
  end

  for (genvar k = 0; k < RW; k++) begin : g_step
    assign r2[k]    = {rem_r[k][RW:0], n_r[k][SQW-1 -: 2]};
    assign trial[k] = {1'b0, root_r[k], 2'b01};
    assign ge[k]    = r2[k] >= trial[k];
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1]  <= ge[k] ? r2[k] - trial[k] : r2[k];
        root_r[k+1] <= {root_r[k][RW-2:0], ge[k]};
        n_r[k+1]    <= {n_r[k][SQW-3:0], 2'b00};
      end
    end
  end

  assign root = root_r[RW];

endmodule

// ===== design/slm_front.sv =====
// Front end: input register, point differences and sums, and the five dot products.
module slm_front import slm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_push,
  output logic     in_full,
  input  slm_in_t  in_data,
  input  logic     q_room,
  output logic     q_push,
  output slm_dot_t q_data
);

  logic en;
  logic [3:0] vld_r;
  slm_in_t in_r;
  logic signed [PW-1:0] p1 [3];
  logic signed [PW-1:0] p2 [3];
  logic signed [DW-1:0] v1 [3];
  logic signed [DW-1:0] v2 [3];
  logic signed [WW-1:0] w1_r  [3];
  logic signed [WW-1:0] ps1_r [3];
  logic signed [DW-1:0] v1_1_r [3];
  logic signed [DW-1:0] v2_1_r [3];
  logic signed [2*DW-1:0]  aa_r [3];
  logic signed [2*DW-1:0]  ab_r [3];
  logic signed [2*DW-1:0]  cc_r [3];
  logic signed [DW+WW-1:0] dd_r [3];
  logic signed [DW+WW-1:0] ee_r [3];
  logic signed [DW-1:0] v1_2_r [3];
  logic signed [DW-1:0] v2_2_r [3];
  logic signed [WW-1:0] w2_r  [3];
  logic signed [WW-1:0] ps2_r [3];
  slm_dot_t q_data_r;

  assign en      = q_room;
  assign in_full = !en;
  assign q_push  = en && vld_r[3];
  assign q_data  = q_data_r;

  assign p1[0] = in_r.p1_x;
  assign p1[1] = in_r.p1_y;
  assign p1[2] = in_r.p1_z;
  assign p2[0] = in_r.p2_x;
  assign p2[1] = in_r.p2_y;
  assign p2[2] = in_r.p2_z;
  assign v1[0] = in_r.v1_x;
  assign v1[1] = in_r.v1_y;
  assign v1[2] = in_r.v1_z;
  assign v2[0] = in_r.v2_x;
  assign v2[1] = in_r.v2_y;
  assign v2[2] = in_r.v2_z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[2:0], in_push};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      in_r <= in_data;
      for (int k = 0; k < 3; k++) begin
        w1_r[k]   <= WW'(p1[k]) - WW'(p2[k]);
        ps1_r[k]  <= WW'(p1[k]) + WW'(p2[k]);
        v1_1_r[k] <= v1[k];
        v2_1_r[k] <= v2[k];
        aa_r[k]   <= v1_1_r[k] * v1_1_r[k];
        ab_r[k]   <= v1_1_r[k] * v2_1_r[k];
        cc_r[k]   <= v2_1_r[k] * v2_1_r[k];
        dd_r[k]   <= v1_1_r[k] * w1_r[k];
        ee_r[k]   <= v2_1_r[k] * w1_r[k];
        v1_2_r[k] <= v1_1_r[k];
        v2_2_r[k] <= v2_1_r[k];
        w2_r[k]   <= w1_r[k];
        ps2_r[k]  <= ps1_r[k];
        q_data_r.v1[k] <= v1_2_r[k];
        q_data_r.v2[k] <= v2_2_r[k];
        q_data_r.w[k]  <= w2_r[k];
        q_data_r.ps[k] <= ps2_r[k];
      end
      q_data_r.a <= ABW'(aa_r[0]) + ABW'(aa_r[1]) + ABW'(aa_r[2]);
      q_data_r.b <= ABW'(ab_r[0]) + ABW'(ab_r[1]) + ABW'(ab_r[2]);
      q_data_r.c <= ABW'(cc_r[0]) + ABW'(cc_r[1]) + ABW'(cc_r[2]);
      q_data_r.d <= DEW'(dd_r[0]) + DEW'(dd_r[1]) + DEW'(dd_r[2]);
      q_data_r.e <= DEW'(ee_r[0]) + DEW'(ee_r[1]) + DEW'(ee_r[2]);
    end
  end

endmodule

// ===== design/slm_queue.sv =====
// Two-entry queue carrying dot products from the front end to the back end.
module slm_queue import slm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  slm_dot_t din,
  output logic     room,
  output logic     nonempty,
  input  logic     pop,
  output slm_dot_t dout
);

  slm_dot_t mem_r [2];
  logic wp_r;
  logic rp_r;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;

  assign room     = cnt_r != 2'd2;
  assign nonempty = cnt_r != 2'd0;
  assign dout     = mem_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= !wp_r;
      end
      if (pop) begin
        rp_r <= !rp_r;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= din;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("queue count out of range");
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && !pop && cnt_r == 2'd2))
    else $error("transfer into a full queue");
  a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && cnt_r == 2'd0))
    else $error("transfer out of an empty queue");

endmodule

// ===== design/slm_back.sv =====
// Back end: denominator, numerators, divisions, midpoint, distance and result queue.
module slm_back import slm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     q_valid,
  input  slm_dot_t q_data,
  output logic     q_pop,
  output logic     out_empty,
  input  logic     out_pop,
  output slm_out_t out_data
);

  typedef struct packed {
    logic               par;
    logic [2:0][WW-1:0] ps;
    logic [2:0][WW-1:0] w;
  } slm_carry_t;

  typedef struct packed {
    logic               par;
    logic               sat;
    logic [2:0][PW-1:0] mid;
  } slm_tail_t;

  localparam logic signed [PW-1:0] SMAX = {1'b0, {(PW-1){1'b1}}};
  localparam logic signed [PW-1:0] SMIN = {1'b1, {(PW-1){1'b0}}};

  logic en;
  logic [BACK_LAT-1:0] vld_r;
  logic o_push;
  logic o_pop;
  slm_out_t omem_r [2];
  logic owp_r;
  logic orp_r;
  logic [1:0] ocnt_r;
  logic [1:0] ocnt_nxt;

  logic signed [EHW-1:0] eh_e;
  logic signed [ELW-1:0] el_e;
  logic signed [EHW-1:0] eh_d;
  logic signed [ELW-1:0] el_d;
  logic signed [2*ABW-1:0] ac_r;
  logic signed [2*ABW-1:0] bb_r;
  logic signed [ABW+EHW-1:0] bxeh_r, cxdh_r, axeh_r, bxdh_r;
  logic signed [ABW+ELW-1:0] bxel_r, cxdl_r, axel_r, bxdl_r;
  slm_dot_t d1_r, d2_r, d3_r, d4_r;

  logic signed [DENW-1:0] den_r, den3_r, den4_r;
  logic signed [NW-1:0] ns_r, nt_r;
  logic signed [NHW-1:0] nsh, nth;
  logic signed [NLW-1:0] nsl, ntl;
  logic signed [DW+NHW-1:0] p1h_r [3];
  logic signed [DW+NLW-1:0] p1l_r [3];
  logic signed [DW+NHW-1:0] p2h_r [3];
  logic signed [DW+NLW-1:0] p2l_r [3];
  logic par3_r, par4_r;
  logic signed [PNW-1:0] num1_r [3];
  logic signed [PNW-1:0] num2_r [3];

  logic signed [QSW-1:0] o1 [3];
  logic signed [QSW-1:0] o2 [3];
  slm_carry_t dly_r [DIV_LAT];
  slm_carry_t dl;

  logic signed [MSW-1:0] msum_r [3];
  logic signed [MSW-1:0] df_r   [3];
  logic pm_r;

  logic signed [MSW-1:0] mh  [3];
  logic [MSW-1:0]        mag [3];
  logic                  ovf [3];
  logic [PW-1:0]         midc [3];
  logic [DFW-1:0]        dfa  [3];
  logic [DFW-1:0]        dfa_r [3];
  slm_tail_t             tail_r [TAIL_N];
  logic [2*DFW-1:0]      sq_r [3];
  logic [SQW-1:0]        sum_r;
  logic [RW-1:0]         root;
  logic                  dsat;
  slm_tail_t             tl;
  slm_out_t              res;

  assign en        = ocnt_r != 2'd2;
  assign q_pop     = en && q_valid;
  assign o_push    = en && vld_r[BACK_LAT-1];
  assign o_pop     = out_pop && ocnt_r != 2'd0;
  assign out_empty = ocnt_r == 2'd0;
  assign out_data  = omem_r[orp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[BACK_LAT-2:0], q_pop};
    end
  end

  assign eh_e = $signed(q_data.e[DEW-1:ESPL]);
  assign el_e = $signed({1'b0, q_data.e[ESPL-1:0]});
  assign eh_d = $signed(q_data.d[DEW-1:ESPL]);
  assign el_d = $signed({1'b0, q_data.d[ESPL-1:0]});
  assign nsh  = $signed(ns_r[NW-1:NSPL]);
  assign nsl  = $signed({1'b0, ns_r[NSPL-1:0]});
  assign nth  = $signed(nt_r[NW-1:NSPL]);
  assign ntl  = $signed({1'b0, nt_r[NSPL-1:0]});

  always_ff @(posedge clk) begin
    if (en) begin
      ac_r   <= q_data.a * q_data.c;
      bb_r   <= q_data.b * q_data.b;
      bxeh_r <= q_data.b * eh_e;
      bxel_r <= q_data.b * el_e;
      cxdh_r <= q_data.c * eh_d;
      cxdl_r <= q_data.c * el_d;
      axeh_r <= q_data.a * eh_e;
      axel_r <= q_data.a * el_e;
      bxdh_r <= q_data.b * eh_d;
      bxdl_r <= q_data.b * el_d;
      d1_r   <= q_data;

      den_r <= DENW'(ac_r) - DENW'(bb_r);
      ns_r  <= (NW'(bxeh_r) <<< ESPL) + NW'(bxel_r) - (NW'(cxdh_r) <<< ESPL) - NW'(cxdl_r);
      nt_r  <= (NW'(axeh_r) <<< ESPL) + NW'(axel_r) - (NW'(bxdh_r) <<< ESPL) - NW'(bxdl_r);
      d2_r  <= d1_r;

      for (int k = 0; k < 3; k++) begin
        p1h_r[k] <= $signed(d2_r.v1[k]) * nsh;
        p1l_r[k] <= $signed(d2_r.v1[k]) * nsl;
        p2h_r[k] <= $signed(d2_r.v2[k]) * nth;
        p2l_r[k] <= $signed(d2_r.v2[k]) * ntl;
      end
      den3_r <= den_r;
      par3_r <= den_r == '0;
      d3_r   <= d2_r;

      for (int k = 0; k < 3; k++) begin
        num1_r[k] <= (PNW'(p1h_r[k]) <<< NSPL) + PNW'(p1l_r[k]);
        num2_r[k] <= (PNW'(p2h_r[k]) <<< NSPL) + PNW'(p2l_r[k]);
      end
      den4_r <= den3_r;
      par4_r <= par3_r;
      d4_r   <= d3_r;
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_div
    slm_div u_div1 (
      .clk  (clk),
      .en   (en),
      .num  (num1_r[k]),
      .den  (den4_r),
      .zero (par4_r),
      .quo  (o1[k])
    );
    slm_div u_div2 (
      .clk  (clk),
      .en   (en),
      .num  (num2_r[k]),
      .den  (den4_r),
      .zero (par4_r),
      .quo  (o2[k])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dly_r[0] <= '{par: par4_r, ps: d4_r.ps, w: d4_r.w};
      for (int j = 1; j < DIV_LAT; j++) begin
        dly_r[j] <= dly_r[j-1];
      end
    end
  end

  assign dl = dly_r[DIV_LAT-1];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        msum_r[k] <= MSW'($signed(dl.ps[k])) + MSW'(o1[k]) + MSW'(o2[k]);
        df_r[k]   <= MSW'($signed(dl.w[k])) + MSW'(o1[k]) - MSW'(o2[k]);
      end
      pm_r <= dl.par;
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mh[k]   = msum_r[k] >>> 1;
      ovf[k]  = !((&mh[k][MSW-1:PW-1]) || !(|mh[k][MSW-1:PW-1]));
      midc[k] = ovf[k] ? (mh[k][MSW-1] ? SMIN : SMAX) : mh[k][PW-1:0];
      mag[k]  = df_r[k][MSW-1] ? MSW'(-df_r[k]) : MSW'(df_r[k]);
      dfa[k]  = (|mag[k][MSW-1:PW]) ? (DFW'(1) << PW) : mag[k][DFW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tail_r[0].par <= pm_r;
      tail_r[0].sat <= ovf[0] || ovf[1] || ovf[2];
      for (int k = 0; k < 3; k++) begin
        tail_r[0].mid[k] <= midc[k];
        dfa_r[k]         <= dfa[k];
        sq_r[k]          <= dfa_r[k] * dfa_r[k];
      end
      for (int j = 1; j < TAIL_N; j++) begin
        tail_r[j] <= tail_r[j-1];
      end
      sum_r <= SQW'(sq_r[0]) + SQW'(sq_r[1]) + SQW'(sq_r[2]);
    end
  end

  slm_sqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .rad  (sum_r),
    .root (root)
  );

  assign tl   = tail_r[TAIL_N-1];
  assign dsat = |root[RW-1:PW];

  always_comb begin
    res.mid_x          = tl.mid[0];
    res.mid_y          = tl.mid[1];
    res.mid_z          = tl.mid[2];
    res.line_distance  = dsat ? '1 : root[PW-1:0];
    res.lines_parallel = tl.par;
    res.saturated      = tl.sat || dsat;
  end

  always_comb begin
    ocnt_nxt = ocnt_r;
    if (o_push && !o_pop) begin
      ocnt_nxt = ocnt_r + 2'd1;
    end else if (o_pop && !o_push) begin
      ocnt_nxt = ocnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owp_r  <= 1'b0;
      orp_r  <= 1'b0;
      ocnt_r <= '0;
    end else begin
      if (o_push) begin
        owp_r <= !owp_r;
      end
      if (o_pop) begin
        orp_r <= !orp_r;
      end
      ocnt_r <= ocnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (o_push) begin
      omem_r[owp_r] <= res;
    end
  end

  a_ocnt_bound: assert property (@(posedge clk) disable iff (!rst_n) ocnt_r != 2'd3)
    else $error("result queue count out of range");
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r))
    else $error("pipeline moved while stalled");
  a_empty_stays: assert property (@(posedge clk) disable iff (!rst_n)
    (ocnt_r == 2'd0 && !o_push) |=> ocnt_r == 2'd0)
    else $error("result appeared without a transfer from the pipeline");

endmodule

// ===== design/skew_line_midpoint.sv =====
// Top level: closest points of two 3D lines, their midpoint and separation.
//
//   channel  direction  handshake             payload
//   in       input      in_push / in_full     slm_in_t  (two points, two directions)
//   out      output     out_pop / out_empty   slm_out_t (midpoint, distance, flags)
//
// One item is accepted per cycle while in_full is low, and one result is delivered per cycle when the consumer pops.
// The 102-stage dividers and the 34-stage square root make up most of the pipeline depth.
// Reset clears the valid bits and queue counts; no clearing pass follows.
// A full result queue freezes the back end, and a full middle queue freezes the front end
// and raises in_full.
module skew_line_midpoint import slm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_push,
  output logic     in_full,
  input  slm_in_t  in_data,
  output logic     out_empty,
  input  logic     out_pop,
  output slm_out_t out_data
);

  logic     f_push;
  slm_dot_t f_data;
  logic     q_room;
  logic     q_nonempty;
  logic     b_pop;
  slm_dot_t q_head;

  slm_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_data (in_data),
    .q_room  (q_room),
    .q_push  (f_push),
    .q_data  (f_data)
  );

  slm_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (f_push),
    .din      (f_data),
    .room     (q_room),
    .nonempty (q_nonempty),
    .pop      (b_pop),
    .dout     (q_head)
  );

  slm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_nonempty),
    .q_data    (q_head),
    .q_pop     (b_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule
